### hdl/tps_pkg.sv
// Shared types, constants and Q-format helpers for the trapezoidal profile setpoint block.
// No dependencies.
package tps_pkg;

  localparam int VALUE_W = 32;
  localparam int QDEPTH  = 4;

  typedef logic signed [63:0] word_t;

  localparam word_t WMAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] WMAX65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_ADDH = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_SQRT = 3'd5;

  localparam logic [1:0] PH_ACC  = 2'd0;
  localparam logic [1:0] PH_CRU  = 2'd1;
  localparam logic [1:0] PH_DEC  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [1:0] REG_VMAX = 2'd0;
  localparam logic [1:0] REG_AMAX = 2'd1;

  typedef struct packed {
    logic        [VALUE_W-1:0] elapsed_time;
    logic signed [VALUE_W-1:0] start_position;
    logic signed [VALUE_W-1:0] start_velocity;
    logic signed [VALUE_W-1:0] goal_position;
  } tps_item_t;

  typedef struct packed {
    logic signed [16:0]        accel_out;
    logic signed [VALUE_W-1:0] velocity_out;
    logic signed [VALUE_W-1:0] position_out;
    logic        [1:0]         phase;
  } tps_result_t;

  typedef struct packed {
    logic [2:0] op;
    word_t      a;
    word_t      b;
  } tps_req_t;

  typedef struct packed {
    logic  done;
    word_t res;
  } tps_rsp_t;

  function automatic word_t clamp65(input logic signed [64:0] s);
    if (s > WMAX65) return WMAX;
    else if (s < -WMAX65) return -WMAX;
    else return s[63:0];
  endfunction

  function automatic word_t half(input word_t a);
    word_t h;
    h = a + (a[63] ? 64'sd1 : 64'sd0);
    return h >>> 1;
  endfunction

  function automatic logic signed [64:0] ext(input word_t a);
    return $signed({a[63], a});
  endfunction

  function automatic logic [61:0] mag(input word_t a);
    word_t n;
    n = a[63] ? -a : a;
    return n[61:0];
  endfunction

endpackage

### hdl/trapezoidal_profile_setpoint.sv
// Top level of the trapezoidal velocity profile setpoint generator: config registers,
// front queue and back-end sequencer. Depends on tps_pkg, tps_front, tps_back, tps_unit.
//
// An item is taken when start is high and busy is low; up to four items wait in the
// front queue while the back end works, and busy is high only when that queue is full.
// Each item is planned and evaluated by one shared iterative arithmetic unit (one bit
// per cycle for multiply and divide, two radicand bits per cycle for the root). Each
// result appears on result for exactly one cycle with done high; it cannot be held
// off and must be captured in that cycle. Results come out in input order.
// Configuration writes are always accepted (cfg_ready is high) and take effect
// for items the back end starts afterward.
module trapezoidal_profile_setpoint import tps_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  tps_item_t   item,
  output logic        done,
  output tps_result_t result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] vmax;
  logic [15:0] amax;
  logic        q_valid;
  logic        q_pop;
  tps_item_t   q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vmax <= 16'd1;
      amax <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VMAX: vmax <= cfg_data;
        REG_AMAX: amax <= cfg_data;
        default:  vmax <= vmax;
      endcase
    end
  end

  tps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .out_valid (q_valid),
    .out_item  (q_item),
    .pop       (q_pop)
  );

  tps_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item       (q_item),
    .pop        (q_pop),
    .vmax       (vmax),
    .amax       (amax),
    .done       (done),
    .result     (result)
  );

endmodule

### hdl/tps_front.sv
// Front end: start/busy handshake and the item queue feeding the back end.
// Depends on tps_pkg.
module tps_front import tps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  tps_item_t item,
  output logic      busy,
  output logic      out_valid,
  output tps_item_t out_item,
  input  logic      pop
);

  localparam int PW = $clog2(QDEPTH);

  tps_item_t     mem [QDEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW-1:0] rp_next;
  logic [PW:0]   cnt;
  logic          push;
  logic          head_new;

  assign busy      = (cnt == (PW+1)'(QDEPTH));
  assign push      = start && !busy;
  assign out_valid = (cnt != '0);
  assign rp_next   = pop ? rp + 1'b1 : rp;
  assign head_new  = push && ((cnt == '0) || ((cnt == (PW+1)'(1)) && pop));

  // out_item holds the entry at the head after this edge
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= item;
    end
    out_item <= head_new ? item : mem[rp_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

### hdl/tps_unit.sv
// Shared Q-format arithmetic unit: saturating add/sub/add-half, iterative multiply, divide, square root.
// Depends on tps_pkg.
module tps_unit import tps_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  tps_req_t req,
  output tps_rsp_t rsp
);

  localparam logic [6:0] MUL_STEPS = 7'd62;
  localparam logic [6:0] DIV_STEPS = 7'(62 + FRAC_BITS);
  localparam logic [6:0] SQ_STEPS  = 7'd48;
  localparam int         DIV_TOP   = 62 + FRAC_BITS - 1;

  logic         run;
  logic [2:0]   op;
  logic         neg;
  logic [6:0]   cnt;
  logic [127:0] acc;
  logic [127:0] num;
  logic [61:0]  mplier;
  logic [63:0]  rem;
  logic [61:0]  dvs;
  logic [47:0]  root;
  logic [127:0] shp;
  logic [63:0]  rem_d;
  logic [63:0]  rem_s;
  logic [63:0]  trial;
  word_t        rmag;

  assign shp   = acc >> FRAC_BITS;
  assign rem_d = {rem[62:0], num[DIV_TOP]};
  assign rem_s = {rem[61:0], num[95:94]};
  assign trial = 64'({root, 2'b01});

  always_comb begin
    rmag = WMAX;
    case (op)
      OP_MUL:  rmag = (shp > 128'(WMAX)) ? WMAX : shp[63:0];
      OP_DIV:  rmag = (acc > 128'(WMAX)) ? WMAX : acc[63:0];
      OP_SQRT: rmag = 64'(root);
      default: rmag = WMAX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (start) begin
        op <= req.op;
        case (req.op)
          OP_ADD: begin
            rsp.res  <= clamp65(ext(req.a) + ext(req.b));
            rsp.done <= 1'b1;
          end
          OP_SUB: begin
            rsp.res  <= clamp65(ext(req.a) - ext(req.b));
            rsp.done <= 1'b1;
          end
          OP_ADDH: begin
            rsp.res  <= clamp65(ext(req.a) + ext(half(req.b)));
            rsp.done <= 1'b1;
          end
          OP_MUL: begin
            acc    <= '0;
            num    <= 128'(mag(req.a));
            mplier <= mag(req.b);
            neg    <= req.a[63] ^ req.b[63];
            cnt    <= MUL_STEPS;
            run    <= 1'b1;
          end
          OP_DIV: begin
            if (req.b == '0) begin
              rsp.res  <= (req.a == '0) ? 64'sd0 : (req.a[63] ? -WMAX : WMAX);
              rsp.done <= 1'b1;
            end else begin
              acc <= '0;
              rem <= '0;
              num <= 128'(mag(req.a)) << FRAC_BITS;
              dvs <= mag(req.b);
              neg <= req.a[63] ^ req.b[63];
              cnt <= DIV_STEPS;
              run <= 1'b1;
            end
          end
          OP_SQRT: begin
            rem  <= '0;
            root <= '0;
            num  <= 128'(req.a[63] ? 64'd0 : 64'(req.a)) << FRAC_BITS;
            neg  <= 1'b0;
            cnt  <= SQ_STEPS;
            run  <= 1'b1;
          end
          default: begin
            rsp.res  <= '0;
            rsp.done <= 1'b1;
          end
        endcase
      end else if (run) begin
        if (cnt != '0) begin
          cnt <= cnt - 7'd1;
          case (op)
            OP_MUL: begin
              if (mplier[0]) acc <= acc + num;
              num    <= num << 1;
              mplier <= mplier >> 1;
            end
            OP_DIV: begin
              if (rem_d >= 64'(dvs)) begin
                rem <= rem_d - 64'(dvs);
                acc <= {acc[126:0], 1'b1};
              end else begin
                rem <= rem_d;
                acc <= {acc[126:0], 1'b0};
              end
              num <= num << 1;
            end
            OP_SQRT: begin
              if (rem_s >= trial) begin
                rem  <= rem_s - trial;
                root <= {root[46:0], 1'b1};
              end else begin
                rem  <= rem_s;
                root <= {root[46:0], 1'b0};
              end
              num <= num << 2;
            end
            default: begin
              num <= num;
            end
          endcase
        end else begin
          run      <= 1'b0;
          rsp.done <= 1'b1;
          rsp.res  <= neg ? -rmag : rmag;
        end
      end
    end
  end

endmodule

### hdl/tps_back.sv
// Back end: sequencer that plans the profile and evaluates one item on the shared unit.
// Depends on tps_pkg and tps_unit.
module tps_back import tps_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  tps_item_t   item,
  output logic        pop,
  input  logic [15:0] vmax,
  input  logic [15:0] amax,
  output logic        done,
  output tps_result_t result
);

  localparam logic [5:0] S_TS   = 6'd0,  S_XM1  = 6'd1,  S_XM2  = 6'd2,  S_XM3  = 6'd3;
  localparam logic [5:0] S_XS1  = 6'd4,  S_XS2  = 6'd5,  S_DIR  = 6'd6,  S_DT1A = 6'd7;
  localparam logic [5:0] S_DT1  = 6'd8,  S_DT3  = 6'd9,  S_D1M1 = 6'd10, S_D1M2 = 6'd11;
  localparam logic [5:0] S_D1M3 = 6'd12, S_DX1  = 6'd13, S_D3M1 = 6'd14, S_D3M2 = 6'd15;
  localparam logic [5:0] S_D3M3 = 6'd16, S_DX3  = 6'd17, S_D2A  = 6'd18, S_D2B  = 6'd19;
  localparam logic [5:0] S_D2C  = 6'd20, S_DT2  = 6'd21, S_TRA  = 6'd22, S_TRB  = 6'd23;
  localparam logic [5:0] S_TRC  = 6'd24, S_TRD  = 6'd25, S_TRE  = 6'd26, S_TRF  = 6'd27;
  localparam logic [5:0] S_TRG  = 6'd28, S_TRH  = 6'd29, S_T2   = 6'd30, S_T3   = 6'd31;
  localparam logic [5:0] S_X1A  = 6'd32, S_X1B  = 6'd33, S_X1C  = 6'd34, S_X1D  = 6'd35;
  localparam logic [5:0] S_X1E  = 6'd36, S_P0A  = 6'd37, S_P0B  = 6'd38, S_P0C  = 6'd39;
  localparam logic [5:0] S_P0D  = 6'd40, S_P0E  = 6'd41, S_P0F  = 6'd42, S_P0G  = 6'd43;
  localparam logic [5:0] S_P1A  = 6'd44, S_P1B  = 6'd45, S_P1C  = 6'd46, S_P2A  = 6'd47;
  localparam logic [5:0] S_P2B  = 6'd48, S_P2C  = 6'd49, S_P2D  = 6'd50, S_P2E  = 6'd51;
  localparam logic [5:0] S_P2F  = 6'd52, S_P2G  = 6'd53, S_P2H  = 6'd54, S_P2I  = 6'd55;
  localparam logic [5:0] S_P2J  = 6'd56, S_P2K  = 6'd57, S_P2L  = 6'd58, S_OUT  = 6'd59;

  logic       running;
  logic       issued;
  logic [5:0] step;
  logic [1:0] ph;
  logic       dneg;
  word_t tq, x0, v0, xg, a_lim, v_lim, ts, xs, aacc, adec, vc;
  word_t dt1, dt2, dt3, dx1, dx3, t2, x1, vel, pos, u, vp, m1, m2, tmp, root, vabs;

  tps_req_t req;
  tps_rsp_t rsp;
  logic     ustart;
  word_t    r;
  logic     v0pos;
  logic [15:0] amax_q;
  logic signed [16:0] amx;

  assign pop    = !running && item_valid;
  assign ustart = running && (step != S_OUT) && !issued;
  assign r      = rsp.res;
  assign v0pos  = !v0[63] && (v0 != '0);
  assign amx    = $signed({1'b0, amax_q});

  tps_unit #(.FRAC_BITS(FRAC_BITS)) u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (ustart),
    .req   (req),
    .rsp   (rsp)
  );

  function automatic logic signed [VALUE_W-1:0] osat(input word_t v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) return 32'sh8000_0000;
    else return v[VALUE_W-1:0];
  endfunction

  always_comb begin
    req.op = OP_ADD;
    req.a  = '0;
    req.b  = '0;
    case (step)
      S_TS:   begin req.op = OP_DIV;  req.a = v0[63] ? -v0 : v0; req.b = a_lim; end
      S_XM1:  begin req.op = OP_MUL;  req.a = v0;   req.b = ts;   end
      S_XM2:  begin req.op = OP_MUL;  req.a = v0pos ? -a_lim : a_lim; req.b = ts; end
      S_XM3:  begin req.op = OP_MUL;  req.a = m2;   req.b = ts;   end
      S_XS1:  begin req.op = OP_ADD;  req.a = x0;   req.b = m1;   end
      S_XS2:  begin req.op = OP_ADDH; req.a = xs;   req.b = m2;   end
      S_DIR:  begin req.op = OP_SUB;  req.a = xg;   req.b = xs;   end
      S_DT1A: begin req.op = OP_SUB;  req.a = vc;   req.b = v0;   end
      S_DT1:  begin req.op = OP_DIV;  req.a = tmp;  req.b = aacc; end
      S_DT3:  begin req.op = OP_DIV;  req.a = -vc;  req.b = adec; end
      S_D1M1: begin req.op = OP_MUL;  req.a = v0;   req.b = dt1;  end
      S_D1M2: begin req.op = OP_MUL;  req.a = aacc; req.b = dt1;  end
      S_D1M3: begin req.op = OP_MUL;  req.a = m2;   req.b = dt1;  end
      S_DX1:  begin req.op = OP_ADDH; req.a = m1;   req.b = m2;   end
      S_D3M1: begin req.op = OP_MUL;  req.a = vc;   req.b = dt3;  end
      S_D3M2: begin req.op = OP_MUL;  req.a = adec; req.b = dt3;  end
      S_D3M3: begin req.op = OP_MUL;  req.a = m2;   req.b = dt3;  end
      S_DX3:  begin req.op = OP_ADDH; req.a = m1;   req.b = m2;   end
      S_D2A:  begin req.op = OP_ADD;  req.a = x0;   req.b = dx1;  end
      S_D2B:  begin req.op = OP_ADD;  req.a = tmp;  req.b = dx3;  end
      S_D2C:  begin req.op = OP_SUB;  req.a = xg;   req.b = tmp;  end
      S_DT2:  begin req.op = OP_DIV;  req.a = tmp;  req.b = vc;   end
      S_TRA:  begin req.op = OP_SUB;  req.a = xg;   req.b = x0;   end
      S_TRB:  begin req.op = OP_MUL;  req.a = aacc; req.b = tmp;  end
      S_TRC:  begin req.op = OP_MUL;  req.a = v0;   req.b = v0;   end
      S_TRD:  begin req.op = OP_ADDH; req.a = root; req.b = m2;   end
      S_TRE:  begin req.op = OP_SQRT; req.a = root; req.b = '0;   end
      S_TRF:  begin req.op = OP_SUB;  req.a = dneg ? -vabs : vabs; req.b = v0; end
      S_TRG:  begin req.op = OP_DIV;  req.a = tmp;  req.b = aacc; end
      S_TRH:  begin req.op = OP_DIV;  req.a = dneg ? vabs : -vabs; req.b = adec; end
      S_T2:   begin req.op = OP_ADD;  req.a = dt1;  req.b = dt2;  end
      S_T3:   begin req.op = OP_ADD;  req.a = t2;   req.b = dt3;  end
      S_X1A:  begin req.op = OP_MUL;  req.a = v0;   req.b = dt1;  end
      S_X1B:  begin req.op = OP_MUL;  req.a = aacc; req.b = dt1;  end
      S_X1C:  begin req.op = OP_MUL;  req.a = m2;   req.b = dt1;  end
      S_X1D:  begin req.op = OP_ADD;  req.a = x0;   req.b = m1;   end
      S_X1E:  begin req.op = OP_ADDH; req.a = x1;   req.b = m2;   end
      S_P0A:  begin req.op = OP_MUL;  req.a = aacc; req.b = tq;   end
      S_P0B:  begin req.op = OP_ADD;  req.a = v0;   req.b = m1;   end
      S_P0C:  begin req.op = OP_MUL;  req.a = v0;   req.b = tq;   end
      S_P0D:  begin req.op = OP_MUL;  req.a = aacc; req.b = tq;   end
      S_P0E:  begin req.op = OP_MUL;  req.a = m2;   req.b = tq;   end
      S_P0F:  begin req.op = OP_ADD;  req.a = x0;   req.b = m1;   end
      S_P0G:  begin req.op = OP_ADDH; req.a = pos;  req.b = m2;   end
      S_P1A:  begin req.op = OP_SUB;  req.a = tq;   req.b = dt1;  end
      S_P1B:  begin req.op = OP_MUL;  req.a = vc;   req.b = tmp;  end
      S_P1C:  begin req.op = OP_ADD;  req.a = x1;   req.b = m1;   end
      S_P2A:  begin req.op = OP_SUB;  req.a = tq;   req.b = t2;   end
      S_P2B:  begin req.op = OP_MUL;  req.a = vc;   req.b = dt2;  end
      S_P2C:  begin req.op = OP_ADD;  req.a = x1;   req.b = m1;   end
      S_P2D:  begin req.op = OP_MUL;  req.a = aacc; req.b = dt1;  end
      S_P2E:  begin req.op = OP_ADD;  req.a = v0;   req.b = m1;   end
      S_P2F:  begin req.op = OP_MUL;  req.a = adec; req.b = u;    end
      S_P2G:  begin req.op = OP_ADD;  req.a = vp;   req.b = m1;   end
      S_P2H:  begin req.op = OP_MUL;  req.a = vp;   req.b = u;    end
      S_P2I:  begin req.op = OP_MUL;  req.a = adec; req.b = u;    end
      S_P2J:  begin req.op = OP_MUL;  req.a = m2;   req.b = u;    end
      S_P2K:  begin req.op = OP_ADD;  req.a = x1;   req.b = m1;   end
      S_P2L:  begin req.op = OP_ADDH; req.a = pos;  req.b = m2;   end
      default: begin req.op = OP_ADD; req.a = '0;   req.b = '0;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      issued  <= 1'b0;
      step    <= S_TS;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (pop) begin
        tq      <= 64'(item.elapsed_time);
        x0      <= 64'(item.start_position);
        v0      <= 64'(item.start_velocity);
        xg      <= 64'(item.goal_position);
        a_lim   <= 64'(amax) << FRAC_BITS;
        v_lim   <= 64'(vmax) << FRAC_BITS;
        amax_q  <= amax;
        running <= 1'b1;
        issued  <= 1'b0;
        step    <= S_TS;
      end else if (running && step == S_OUT) begin
        running <= 1'b0;
        done    <= 1'b1;
        case (ph)
          PH_ACC:  result.accel_out <= dneg ? -amx : amx;
          PH_DEC:  result.accel_out <= dneg ? amx : -amx;
          default: result.accel_out <= '0;
        endcase
        result.velocity_out <= osat(vel);
        result.position_out <= osat(pos);
        result.phase        <= ph;
      end else if (running) begin
        if (ustart) issued <= 1'b1;
        if (rsp.done) begin
          issued <= 1'b0;
          step   <= step + 6'd1;
          case (step)
            S_TS:   ts  <= r;
            S_XM1:  m1  <= r;
            S_XM2:  m2  <= r;
            S_XM3:  m2  <= r;
            S_XS1:  xs  <= r;
            S_XS2:  xs  <= r;
            S_DIR: begin
              dneg <= r[63];
              aacc <= r[63] ? -a_lim : a_lim;
              adec <= r[63] ? a_lim : -a_lim;
              vc   <= r[63] ? -v_lim : v_lim;
            end
            S_DT1A: tmp <= r;
            S_DT1:  dt1 <= r;
            S_DT3:  dt3 <= r;
            S_D1M1: m1  <= r;
            S_D1M2: m2  <= r;
            S_D1M3: m2  <= r;
            S_DX1:  dx1 <= r;
            S_D3M1: m1  <= r;
            S_D3M2: m2  <= r;
            S_D3M3: m2  <= r;
            S_DX3:  dx3 <= r;
            S_D2A:  tmp <= r;
            S_D2B:  tmp <= r;
            S_D2C:  tmp <= r;
            S_DT2: begin
              dt2 <= r;
              step <= r[63] ? S_TRA : S_T2;
            end
            S_TRA:  tmp  <= r;
            S_TRB:  root <= r;
            S_TRC:  m2   <= r;
            S_TRD:  root <= r;
            S_TRE:  vabs <= r;
            S_TRF:  tmp  <= r;
            S_TRG: begin
              dt1 <= r[63] ? -r : r;
              dt2 <= '0;
            end
            S_TRH:  dt3 <= r;
            S_T2:   t2  <= r;
            S_T3: begin
              if (tq < dt1) begin
                ph   <= PH_ACC;
                step <= S_P0A;
              end else if (tq < t2) begin
                ph   <= PH_CRU;
                step <= S_X1A;
              end else if (tq < r) begin
                ph   <= PH_DEC;
                step <= S_X1A;
              end else begin
                ph   <= PH_DONE;
                vel  <= '0;
                pos  <= xg;
                step <= S_OUT;
              end
            end
            S_X1A:  m1 <= r;
            S_X1B:  m2 <= r;
            S_X1C:  m2 <= r;
            S_X1D:  x1 <= r;
            S_X1E: begin
              x1   <= r;
              step <= (ph == PH_CRU) ? S_P1A : S_P2A;
            end
            S_P0A:  m1  <= r;
            S_P0B:  vel <= r;
            S_P0C:  m1  <= r;
            S_P0D:  m2  <= r;
            S_P0E:  m2  <= r;
            S_P0F:  pos <= r;
            S_P0G: begin
              pos  <= r;
              step <= S_OUT;
            end
            S_P1A:  tmp <= r;
            S_P1B:  m1  <= r;
            S_P1C: begin
              pos  <= r;
              vel  <= vc;
              step <= S_OUT;
            end
            S_P2A: begin
              u <= r;
              if (dt2 != '0) begin
                vp   <= vc;
                step <= S_P2B;
              end else begin
                step <= S_P2D;
              end
            end
            S_P2B:  m1 <= r;
            S_P2C: begin
              x1   <= r;
              step <= S_P2F;
            end
            S_P2D:  m1  <= r;
            S_P2E:  vp  <= r;
            S_P2F:  m1  <= r;
            S_P2G:  vel <= r;
            S_P2H:  m1  <= r;
            S_P2I:  m2  <= r;
            S_P2J:  m2  <= r;
            S_P2K:  pos <= r;
            S_P2L:  pos <= r;
            default: tmp <= r;
          endcase
        end
      end
    end
  end

endmodule
